// ===== sv/grfe_pkg.sv =====
// Shared types, constants, microcode program and gamma table of the RGB fade engine.
package grfe_pkg;

  // Largest channel level
  localparam int unsigned LEVEL_MAX = 255;

  // Configuration port geometry: one 32-bit register, word-addressed by paddr[2]
  localparam int unsigned ADDR_W = 3;
  localparam logic [ADDR_W-3:0] REG_DELAY_TICKS = 1'b0;

  // Microcode operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_FETCH,
    OP_START,
    OP_PACE,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_GAMMA,
    OP_MUL,
    OP_SCALE,
    OP_EMIT
  } op_t;

  // Jump conditions
  typedef enum logic [3:0] {
    JMP_NEVER,
    JMP_ALWAYS,
    JMP_NO_ITEM,
    JMP_IS_TICK,
    JMP_NO_STEP,
    JMP_DIV_BUSY,
    JMP_MORE_CHAN,
    JMP_OUT_BUSY
  } cond_t;

  typedef logic [3:0] upc_t;

  // Program addresses
  localparam upc_t UA_FETCH    = 4'd0;
  localparam upc_t UA_DECODE   = 4'd1;
  localparam upc_t UA_START    = 4'd2;
  localparam upc_t UA_PACE     = 4'd3;
  localparam upc_t UA_DIV_INIT = 4'd4;
  localparam upc_t UA_DIV_STEP = 4'd5;
  localparam upc_t UA_GAMMA    = 4'd6;
  localparam upc_t UA_MUL      = 4'd7;
  localparam upc_t UA_SCALE    = 4'd8;
  localparam upc_t UA_EMIT     = 4'd9;
  localparam upc_t UA_RETURN   = 4'd10;
  localparam upc_t UA_LAST     = UA_RETURN;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
  } ctrl_word_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic in_valid;
    logic is_tick;
    logic no_step;
    logic div_busy;
    logic more_chan;
    logic out_busy;
  } flags_t;

  // Control store: a taken jump goes to target, otherwise fall through
  function automatic ctrl_word_t ucode(upc_t addr);
    ctrl_word_t w;
    case (addr)
      UA_FETCH:    w = '{op: OP_FETCH,    cond: JMP_NO_ITEM,   target: UA_FETCH};
      UA_DECODE:   w = '{op: OP_NONE,     cond: JMP_IS_TICK,   target: UA_PACE};
      UA_START:    w = '{op: OP_START,    cond: JMP_ALWAYS,    target: UA_FETCH};
      UA_PACE:     w = '{op: OP_PACE,     cond: JMP_NO_STEP,   target: UA_FETCH};
      UA_DIV_INIT: w = '{op: OP_DIV_INIT, cond: JMP_NEVER,     target: UA_FETCH};
      UA_DIV_STEP: w = '{op: OP_DIV_STEP, cond: JMP_DIV_BUSY,  target: UA_DIV_STEP};
      UA_GAMMA:    w = '{op: OP_GAMMA,    cond: JMP_NEVER,     target: UA_FETCH};
      UA_MUL:      w = '{op: OP_MUL,      cond: JMP_NEVER,     target: UA_FETCH};
      UA_SCALE:    w = '{op: OP_SCALE,    cond: JMP_MORE_CHAN, target: UA_MUL};
      UA_EMIT:     w = '{op: OP_EMIT,     cond: JMP_OUT_BUSY,  target: UA_EMIT};
      UA_RETURN:   w = '{op: OP_NONE,     cond: JMP_ALWAYS,    target: UA_FETCH};
      default:     w = '{op: OP_NONE,     cond: JMP_ALWAYS,    target: UA_FETCH};
    endcase
    return w;
  endfunction

  typedef logic [255:0][7:0] gamma_rom_t;

  // Nearest integer to 255*(p/255)^2.2, from the exact test
  // (2k+1)^5 * 255^6 <= 32 * p^11; evaluated at elaboration only
  function automatic gamma_rom_t build_gamma();
    gamma_rom_t   rom;
    logic [127:0] lhs;
    logic [127:0] rhs;
    int           k;
    int           p;
    int           i;
    logic         done;
    k = 0;
    for (p = 0; p < 256; p++) begin
      rhs = 128'd32;
      for (i = 0; i < 11; i++) rhs = rhs * 128'(p);
      done = 1'b0;
      while (k < 255 && !done) begin
        lhs = 128'd1;
        for (i = 0; i < 5; i++) lhs = lhs * 128'(2 * k + 1);
        for (i = 0; i < 6; i++) lhs = lhs * 128'(LEVEL_MAX);
        if (lhs > rhs) done = 1'b1;
        else k++;
      end
      rom[p] = k[7:0];
    end
    return rom;
  endfunction

  localparam gamma_rom_t GAMMA_ROM = build_gamma();

endpackage

// ===== sv/grfe_sequencer.sv =====
// Microcode sequencer: step counter, control store and conditional jumps.
module grfe_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  grfe_pkg::flags_t    flags,
  output grfe_pkg::ctrl_word_t ctrl,
  output grfe_pkg::upc_t      upc
);
  import grfe_pkg::*;

  logic take;
  upc_t upc_next;

  // Fetch the control word of the current step
  assign ctrl = ucode(upc);

  // Evaluate the jump condition and pick the next step
  always_comb begin
    case (ctrl.cond)
      JMP_NEVER:     take = 1'b0;
      JMP_ALWAYS:    take = 1'b1;
      JMP_NO_ITEM:   take = !flags.in_valid;
      JMP_IS_TICK:   take = flags.is_tick;
      JMP_NO_STEP:   take = flags.no_step;
      JMP_DIV_BUSY:  take = flags.div_busy;
      JMP_MORE_CHAN: take = flags.more_chan;
      JMP_OUT_BUSY:  take = flags.out_busy;
      default:       take = 1'b1;
    endcase
    upc_next = take ? ctrl.target : upc + 4'd1;
  end

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= UA_FETCH;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

// ===== sv/grfe_datapath.sv =====
// Fade datapath: fade state, bit-serial divider, gamma lookup, channel scaling, output register.
module grfe_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  grfe_pkg::ctrl_word_t ctrl,
  input  logic [15:0]          delay_ticks,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 action,
  input  logic [7:0]           start_red,
  input  logic [7:0]           start_green,
  input  logic [7:0]           start_blue,
  input  logic [7:0]           end_red,
  input  logic [7:0]           end_green,
  input  logic [7:0]           end_blue,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           red,
  output logic [7:0]           green,
  output logic [7:0]           blue,
  output logic                 final_step,
  output grfe_pkg::flags_t     flags,
  output logic                 fading
);
  import grfe_pkg::*;

  // Captured input beat
  logic             is_tick;
  logic [2:0][7:0]  item_from;
  logic [2:0][7:0]  item_to;

  // Fade state
  logic [7:0]       step_index;
  logic [7:0]       step_total;
  logic [2:0][7:0]  from_colour;
  logic [2:0][7:0]  to_colour;
  logic [15:0]      wait_left;

  // Divider, gamma and channel work registers
  logic [15:0]      div_q;
  logic [7:0]       div_rem;
  logic [3:0]       div_cnt;
  logic [7:0]       gain;
  logic [1:0]       chan;
  logic [15:0]      prod;
  logic             prod_up;
  logic [2:0][7:0]  level;

  // Combinational helpers
  logic [2:0][7:0]  diff;
  logic [7:0]       total_new;
  logic [8:0]       trial;
  logic             trial_ge;
  logic [7:0]       chan_from;
  logic [7:0]       chan_to;
  logic [7:0]       chan_delta;
  logic [16:0]      scale_sum;
  logic [7:0]       scaled;
  logic             accept;
  logic             emit;

  assign in_stall = (ctrl.op != OP_FETCH);
  assign accept   = in_valid && !in_stall;
  assign emit     = (ctrl.op == OP_EMIT) && !(out_valid && out_stall);

  // Step count: largest per-channel distance
  always_comb begin
    total_new = '0;
    for (int c = 0; c < 3; c++) begin
      diff[c] = (item_to[c] >= item_from[c]) ? item_to[c] - item_from[c]
                                             : item_from[c] - item_to[c];
      if (diff[c] > total_new) total_new = diff[c];
    end
  end

  // One restoring divide step
  assign trial    = {div_rem, div_q[15]};
  assign trial_ge = (trial >= {1'b0, step_total});

  // Channel delta and divide by 255: (x + 1 + (x >> 8)) >> 8 is exact for x below 65535
  assign chan_from  = from_colour[chan];
  assign chan_to    = to_colour[chan];
  assign chan_delta = (chan_to >= chan_from) ? chan_to - chan_from : chan_from - chan_to;
  assign scale_sum  = {1'b0, prod} + 17'd1 + {9'd0, prod[15:8]};
  assign scaled     = scale_sum[15:8];

  // Status for the sequencer
  assign flags.in_valid  = in_valid;
  assign flags.is_tick   = is_tick;
  assign flags.no_step   = !fading || (wait_left > 16'd1);
  assign flags.div_busy  = (div_cnt != 4'd0);
  assign flags.more_chan = (chan != 2'd2);
  assign flags.out_busy  = out_valid && out_stall;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      fading     <= 1'b0;
      step_index <= '0;
      step_total <= '0;
      wait_left  <= '0;
      out_valid  <= 1'b0;
    end else begin
      case (ctrl.op)
        OP_START: begin
          step_total <= total_new;
          step_index <= '0;
          wait_left  <= delay_ticks;
          fading     <= (total_new != 8'd0);
        end
        OP_PACE: begin
          if (fading) begin
            if (wait_left > 16'd1) begin
              wait_left <= wait_left - 16'd1;
            end else begin
              wait_left  <= delay_ticks;
              step_index <= step_index + 8'd1;
            end
          end
        end
        OP_EMIT: begin
          if (emit && step_index >= step_total) fading <= 1'b0;
        end
        default: begin
        end
      endcase
      // Drop the output beat once taken, load a new one on emit
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      is_tick      <= action;
      item_from[0] <= start_red;
      item_from[1] <= start_green;
      item_from[2] <= start_blue;
      item_to[0]   <= end_red;
      item_to[1]   <= end_green;
      item_to[2]   <= end_blue;
    end
    case (ctrl.op)
      OP_START: begin
        from_colour <= item_from;
        to_colour   <= item_to;
      end
      OP_DIV_INIT: begin
        div_q   <= {step_index, 8'd0} - {8'd0, step_index};
        div_rem <= '0;
        div_cnt <= 4'd15;
      end
      OP_DIV_STEP: begin
        div_rem <= trial_ge ? 8'(trial - {1'b0, step_total}) : trial[7:0];
        div_q   <= {div_q[14:0], trial_ge};
        div_cnt <= div_cnt - 4'd1;
      end
      OP_GAMMA: begin
        gain <= GAMMA_ROM[div_q[7:0]];
        chan <= '0;
      end
      OP_MUL: begin
        prod    <= gain * chan_delta;
        prod_up <= (chan_to >= chan_from);
      end
      OP_SCALE: begin
        level[chan] <= prod_up ? chan_from + scaled : chan_from - scaled;
        chan        <= chan + 2'd1;
      end
      default: begin
      end
    endcase
    if (emit) begin
      red        <= level[0];
      green      <= level[1];
      blue       <= level[2];
      final_step <= (step_index >= step_total);
    end
  end

endmodule

// ===== sv/gamma_rgb_fade_engine.sv =====
// A start beat, or a tick that emits nothing, runs the fetch, decode and start or pace steps.
// A tick that emits a colour then runs the 16-step restoring divider, the gamma lookup and a
// multiply and a scale step per channel, and the emit step then loads the output register.
// One item is worked at a time; the output register lets the next beat in while a colour waits.
// Reset (synchronous, active high) clears the fade, sets delay_ticks to 0 and starts
// the sequencer at the fetch step.
module gamma_rgb_fade_engine (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [grfe_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      action,
  input  logic [7:0]                start_red,
  input  logic [7:0]                start_green,
  input  logic [7:0]                start_blue,
  input  logic [7:0]                end_red,
  input  logic [7:0]                end_green,
  input  logic [7:0]                end_blue,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                red,
  output logic [7:0]                green,
  output logic [7:0]                blue,
  output logic                      final_step
);
  import grfe_pkg::*;

  logic       [15:0] delay_ticks;
  logic              reg_hit;
  ctrl_word_t        ctrl;
  upc_t              upc;
  flags_t            flags;
  logic              fading;

  // Configuration register
  assign pready  = 1'b1;
  assign reg_hit = (paddr[ADDR_W-1:2] == REG_DELAY_TICKS);
  assign prdata  = reg_hit ? {16'd0, delay_ticks} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ticks <= '0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      delay_ticks <= pwdata[15:0];
    end
  end

  grfe_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl),
    .upc   (upc)
  );

  grfe_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .delay_ticks (delay_ticks),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .start_red   (start_red),
    .start_green (start_green),
    .start_blue  (start_blue),
    .end_red     (end_red),
    .end_green   (end_green),
    .end_blue    (end_blue),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .final_step  (final_step),
    .flags       (flags),
    .fading      (fading)
  );

  // An accepted beat is always decoded next
  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> upc == UA_DECODE)
    else $error("accepted beat not followed by decode");

  // A new colour only comes from the emit step
  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(upc) == UA_EMIT)
    else $error("output beat raised outside emit step");

  // The step counter stays inside the program
  a_upc_range: assert property (@(posedge clk) disable iff (rst)
    upc <= UA_LAST)
    else $error("step counter left the program");

  // Divide and scale steps only run on a live fade
  a_work_fading: assert property (@(posedge clk) disable iff (rst)
    upc == UA_DIV_INIT |-> fading)
    else $error("divide started with no fade running");

endmodule

// ===== sim/tb_gamma_rgb_fade_engine.sv =====
// Self-checking testbench for the gamma-corrected RGB fade engine.
module tb_gamma_rgb_fade_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import grfe_pkg::*;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_TICK  = 1'b1;
  localparam logic [ADDR_W-3:0] REG_SPARE = 1'b1;
  localparam int SETTLE_CYCLES = 40;
  localparam longint CYCLE_LIMIT = 2_000_000;

  // One input beat: action plus start and end colour, index 0 red, 1 green, 2 blue
  typedef struct {
    logic       action;
    logic [7:0] src [3];
    logic [7:0] dst [3];
  } fade_beat_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       final_step;
  } colour_out_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata, prdata;
  logic              in_valid, in_stall, action;
  logic [7:0]        start_red, start_green, start_blue;
  logic [7:0]        end_red, end_green, end_blue;
  logic              out_valid, out_stall;
  logic [7:0]        red, green, blue;
  logic              final_step;

  // Shadow of the fade engine
  logic [15:0] delay_reg;
  logic        fade_on;
  logic [7:0]  step_no, step_cnt;
  logic [7:0]  from_rgb [3];
  logic [7:0]  to_rgb [3];
  logic [15:0] wait_cnt;
  logic [7:0]  gamma_lut [256];

  colour_out_t pending_colours [$];
  int          errors = 0;
  int          items_sent = 0;
  bit          idle_on = 1'b1;
  longint      cycles = 0;

  gamma_rgb_fade_engine dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .action(action),
    .start_red(start_red), .start_green(start_green), .start_blue(start_blue),
    .end_red(end_red), .end_green(end_green), .end_blue(end_blue),
    .out_valid(out_valid), .out_stall(out_stall),
    .red(red), .green(green), .blue(blue), .final_step(final_step)
  );

  always #4 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Gamma 2.2 table: count the half-steps (2k+1)/2 with (2k+1)^5*255^6 <= 32*p^11
  function automatic void build_gamma_lut();
    logic [127:0] lim;
    logic [127:0] probe;
    int           g;
    int           p;
    int           i;
    g = 0;
    for (p = 0; p < 256; p++) begin
      lim = 128'd32;
      for (i = 0; i < 11; i++) lim = lim * 128'(p);
      while (g < 255) begin
        probe = 128'd1;
        for (i = 0; i < 5; i++) probe = probe * 128'(2 * g + 1);
        for (i = 0; i < 6; i++) probe = probe * 128'd255;
        if (probe > lim) break;
        g++;
      end
      gamma_lut[p] = 8'(g);
    end
  endfunction

  // Advance the shadow state by one accepted beat and queue any colour it emits
  function automatic void apply_beat(input fade_beat_t b);
    logic [7:0]  span;
    logic [7:0]  d;
    int          pos;
    int          g;
    int          c;
    int          v [3];
    colour_out_t col;
    if (b.action == ACT_START) begin
      span = 8'd0;
      for (c = 0; c < 3; c++) begin
        d = (b.dst[c] >= b.src[c]) ? b.dst[c] - b.src[c] : b.src[c] - b.dst[c];
        from_rgb[c] = b.src[c];
        to_rgb[c]   = b.dst[c];
        if (d > span) span = d;
      end
      step_cnt = span;
      step_no  = 8'd0;
      wait_cnt = delay_reg;
      fade_on  = (span != 8'd0);
    end else if (fade_on) begin
      if (wait_cnt > 16'd1) begin
        wait_cnt--;
      end else begin
        wait_cnt = delay_reg;
        step_no++;
        pos = (int'(step_no) * int'(LEVEL_MAX)) / int'(step_cnt);
        g = int'(gamma_lut[pos]);
        for (c = 0; c < 3; c++) begin
          if (to_rgb[c] >= from_rgb[c])
            v[c] = int'(from_rgb[c]) + g * int'(to_rgb[c] - from_rgb[c]) / 255;
          else
            v[c] = int'(from_rgb[c]) - g * int'(from_rgb[c] - to_rgb[c]) / 255;
        end
        col.red        = 8'(v[0]);
        col.green      = 8'(v[1]);
        col.blue       = 8'(v[2]);
        col.final_step = (step_no >= step_cnt);
        if (col.final_step) fade_on = 1'b0;
        pending_colours.push_back(col);
      end
    end
  endfunction

  // Drive one beat, with an optional idle burst ahead of it, and hold it until taken
  task automatic send_beat(input fade_beat_t b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    action      <= b.action;
    start_red   <= b.src[0];
    start_green <= b.src[1];
    start_blue  <= b.src[2];
    end_red     <= b.dst[0];
    end_green   <= b.dst[1];
    end_blue    <= b.dst[2];
    do @(posedge clk); while (in_stall);
    apply_beat(b);
    items_sent++;
  endtask

  // Tick with random colour bits, which the block must ignore
  task automatic send_tick();
    fade_beat_t b;
    int         c;
    b.action = ACT_TICK;
    for (c = 0; c < 3; c++) begin
      b.src[c] = 8'($urandom);
      b.dst[c] = 8'($urandom);
    end
    send_beat(b);
  endtask

  task automatic send_start(input logic [7:0] sr, sg, sb, er, eg, eb);
    fade_beat_t b;
    b.action = ACT_START;
    b.src[0] = sr;
    b.src[1] = sg;
    b.src[2] = sb;
    b.dst[0] = er;
    b.dst[1] = eg;
    b.dst[2] = eb;
    send_beat(b);
  endtask

  // Drop valid, drain every expected colour, then let the sequencer settle
  task automatic quiesce();
    @(negedge clk) in_valid <= 1'b0;
    while (pending_colours.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write a register while idle, then read back the delay register
  task automatic set_delay(input logic [ADDR_W-3:0] idx, input logic [31:0] val);
    quiesce();
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_DELAY_TICKS) delay_reg = val[15:0];
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= {REG_DELAY_TICKS, 2'b00};
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {16'h0000, delay_reg}) begin
      $display("%0t: delay_ticks readback expected %h actual %h", $time,
               {16'h0000, delay_reg}, prdata);
      errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [7:0] nudge(input logic [7:0] v);
    int t;
    t = int'(v) + int'($urandom_range(0, 18)) - 9;
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return 8'(t);
  endfunction

  // One random fade: mostly complete runs, some cut short by a restart
  task automatic random_fade();
    logic [7:0] s [3];
    logic [7:0] e [3];
    int         mode;
    int         c;
    int         needed;
    int         ticks;
    if ($urandom_range(0, 5) == 0) send_tick();
    mode = $urandom_range(0, 15);
    for (c = 0; c < 3; c++) begin
      s[c] = 8'($urandom);
      if (mode == 0) e[c] = 8'($urandom);
      else if (mode == 1) e[c] = s[c];
      else e[c] = nudge(s[c]);
    end
    send_start(s[0], s[1], s[2], e[0], e[1], e[2]);
    needed = fade_on ? int'(step_cnt) * ((delay_reg > 16'd1) ? int'(delay_reg) : 1) : 0;
    if ($urandom_range(0, 4) == 0) ticks = $urandom_range(0, needed);
    else ticks = needed + $urandom_range(0, 2);
    repeat (ticks) send_tick();
  endtask

  // Extremes, each operation, idle ticks, equal colours and restarts
  task automatic test_directed();
    send_tick();
    send_start(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_tick();
    send_start(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
    repeat (3) send_tick();
    send_start(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
    repeat (2) send_tick();
    send_start(8'd10, 8'd200, 8'd30, 8'd11, 8'd200, 8'd29);
    repeat (2) send_tick();
    send_start(8'd200, 8'd0, 8'd100, 8'd197, 8'd3, 8'd100);
    repeat (3) send_tick();
    send_start(8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0);
    repeat (2) send_tick();
    send_start(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255);
    repeat (2) send_tick();
    send_start(8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128);
    send_tick();
  endtask

  // Tick pacing for delays of 1 and 3, upper-bit masking, and the spare address
  task automatic test_pacing();
    set_delay(REG_DELAY_TICKS, 32'd1);
    send_start(8'd5, 8'd5, 8'd5, 8'd7, 8'd5, 8'd5);
    repeat (3) send_tick();
    set_delay(REG_DELAY_TICKS, 32'hFFFF_0003);
    send_start(8'd0, 8'd0, 8'd0, 8'd4, 8'd0, 8'd0);
    repeat (13) send_tick();
    set_delay(REG_SPARE, 32'h0000_0007);
    send_start(8'd9, 8'd9, 8'd9, 8'd8, 8'd8, 8'd8);
    repeat (4) send_tick();
  endtask

  // Random fades in blocks, each block with its own delay and idling choice
  task automatic test_random_fades(input int target);
    int block_end;
    while (items_sent < target) begin
      idle_on = ($urandom_range(0, 3) != 0);
      set_delay(REG_DELAY_TICKS, {16'($urandom), 16'($urandom_range(0, 4))});
      block_end = items_sent + 150;
      while (items_sent < block_end) random_fade();
    end
  endtask

  // Back-to-back beats with no idling on either side
  task automatic test_quiet_tail(input int count);
    int stop_at;
    idle_on = 1'b0;
    set_delay(REG_DELAY_TICKS, 32'd0);
    stop_at = items_sent + count;
    while (items_sent < stop_at) random_fade();
  endtask

  // Largest delay: the wait counts down from 65535 and no colour comes out
  task automatic test_max_delay();
    set_delay(REG_DELAY_TICKS, 32'h0000_FFFF);
    send_start(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1);
    repeat (40) send_tick();
  endtask

  // Random output stall bursts
  initial begin
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each accepted colour with the oldest expected one
  always @(posedge clk) begin : check_colour
    colour_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_colours.size() == 0) begin
        $display("%0t: unexpected colour r=%0d g=%0d b=%0d final=%0b", $time,
                 red, green, blue, final_step);
        errors++;
      end else begin
        want = pending_colours.pop_front();
        if (red !== want.red || green !== want.green || blue !== want.blue ||
            final_step !== want.final_step) begin
          $display("%0t: colour mismatch expected r=%0d g=%0d b=%0d final=%0b",
                   $time, want.red, want.green, want.blue, want.final_step);
          $display("%0t:                   actual r=%0d g=%0d b=%0d final=%0b",
                   $time, red, green, blue, final_step);
          errors++;
        end
      end
    end
  end

  initial begin
    rst         = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid    = 1'b0;
    action      = ACT_TICK;
    start_red   = '0;
    start_green = '0;
    start_blue  = '0;
    end_red     = '0;
    end_green   = '0;
    end_blue    = '0;
    out_stall   = 1'b0;
    delay_reg   = '0;
    fade_on     = 1'b0;
    step_no     = '0;
    step_cnt    = '0;
    wait_cnt    = '0;
    for (int c = 0; c < 3; c++) begin
      from_rgb[c] = '0;
      to_rgb[c]   = '0;
    end
    build_gamma_lut();
    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    test_directed();
    test_pacing();
    test_random_fades(950);
    test_quiet_tail(100);
    test_max_delay();

    quiesce();
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
